@@ src/clt_pkg.sv @@
package clt_pkg;

    typedef enum logic [2:0] {
        MODE_SKIP    = 3'd0,
        MODE_NORMAL  = 3'd1,
        MODE_ESCAPE  = 3'd2,
        MODE_CARET   = 3'd3,
        MODE_COMMENT = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        QUOTE_NONE   = 2'd0,
        QUOTE_SINGLE = 2'd1,
        QUOTE_DOUBLE = 2'd2
    } t_quote;

    typedef struct packed {
        t_mode       mode;
        t_quote      quote;
        logic        word_open;
        logic [15:0] bytes_emitted;
    } t_state;

    typedef struct packed {
        logic [7:0] data;
        logic       done;
        logic       eof;
        logic       last;
    } t_result;

    localparam int unsigned RES_MAX = 3;

    localparam logic [15:0] CAP_RESET = 16'd1024;

    localparam logic [7:0] CH_AT         = 8'h40;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_CARET      = 8'h5E;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_N          = 8'h6E;
    localparam logic [7:0] CH_T          = 8'h74;
    localparam logic [7:0] CH_R          = 8'h72;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;

endpackage

@@ src/clt_step.sv @@
module clt_step import clt_pkg::*; (
    input  t_state                 i_state,
    input  logic [15:0]            i_cap,
    input  logic [7:0]             i_byte,
    input  logic                   i_eof,
    output t_state                 o_state,
    output t_result [RES_MAX-1:0]  o_res,
    output logic [1:0]             o_cnt
);

    t_state                st;
    t_result [RES_MAX-1:0] res;
    logic [1:0]            cnt;
    logic                  ord_a;
    logic [7:0]            byte_a;
    logic                  ord_b;
    logic                  handle;
    logic                  endl;
    logic                  endeof;
    logic                  blank;
    logic                  nl;
    t_quote                q;

    always_comb begin
        st     = i_state;
        res    = '0;
        cnt    = 2'd0;
        ord_a  = 1'b0;
        byte_a = CH_CARET;
        ord_b  = 1'b0;
        handle = 1'b0;
        endl   = 1'b0;
        endeof = 1'b0;
        blank  = (i_byte == CH_SPACE) || (i_byte == CH_TAB);
        nl     = (i_byte == CH_LF);
        q      = (i_byte == CH_SQUOTE) ? QUOTE_SINGLE :
                 (i_byte == CH_DQUOTE) ? QUOTE_DOUBLE : QUOTE_NONE;

        if (i_eof) begin
            if (i_state.mode == MODE_CARET) begin
                ord_a = 1'b1;
            end
            endl   = 1'b1;
            endeof = 1'b1;
        end else begin
            case (i_state.mode)
                MODE_SKIP: begin
                    if (!blank) begin
                        st.mode = MODE_NORMAL;
                        handle  = 1'b1;
                    end
                end
                MODE_ESCAPE: begin
                    if (nl) begin
                        // line continuation
                        st.mode = MODE_NORMAL;
                    end else begin
                        ord_a = 1'b1;
                        if (i_byte == CH_N) begin
                            byte_a = CH_LF;
                        end else if (i_byte == CH_T) begin
                            byte_a = CH_TAB;
                        end else if (i_byte == CH_R) begin
                            byte_a = CH_CR;
                        end else begin
                            byte_a = i_byte;
                        end
                    end
                end
                MODE_CARET: begin
                    ord_a = 1'b1;
                    if (i_byte >= CH_AT && i_byte <= CH_UNDERSCORE) begin
                        byte_a = i_byte - CH_AT;
                    end else begin
                        // literal caret, then treat the follower as a fresh byte
                        handle = 1'b1;
                    end
                end
                MODE_COMMENT: begin
                    endl = nl;
                end
                default: begin
                    handle = 1'b1;
                end
            endcase
        end

        if (ord_a) begin
            if (({1'b0, st.bytes_emitted} + 17'd2) < {1'b0, i_cap}) begin
                if (cnt != 2'd3) begin
                    res[cnt] = '{data: byte_a, done: 1'b0, eof: 1'b0, last: 1'b0};
                end
                cnt = cnt + 2'd1;
                if (st.bytes_emitted != 16'hFFFF) begin
                    st.bytes_emitted = st.bytes_emitted + 16'd1;
                end
                st.word_open = 1'b1;
            end
            st.mode = MODE_NORMAL;
        end

        if (handle) begin
            if (nl) begin
                endl = 1'b1;
            end else if (i_byte == CH_BACKSLASH) begin
                st.mode = MODE_ESCAPE;
            end else if (i_byte == CH_CARET) begin
                st.mode = MODE_CARET;
            end else if (st.quote != QUOTE_NONE) begin
                if (q == st.quote) begin
                    st.quote = QUOTE_NONE;
                    st.mode  = MODE_NORMAL;
                end else begin
                    ord_b = 1'b1;
                end
            end else if (q != QUOTE_NONE) begin
                st.quote = q;
                st.mode  = MODE_NORMAL;
            end else if (i_byte == CH_HASH || blank) begin
                // separator is sent even on a full line
                if (cnt != 2'd3) begin
                    res[cnt] = '{data: 8'h00, done: 1'b0, eof: 1'b0, last: 1'b0};
                end
                cnt = cnt + 2'd1;
                if (st.bytes_emitted != 16'hFFFF) begin
                    st.bytes_emitted = st.bytes_emitted + 16'd1;
                end
                st.word_open = 1'b0;
                st.mode      = blank ? MODE_SKIP : MODE_COMMENT;
            end else begin
                ord_b = 1'b1;
            end
        end

        if (ord_b) begin
            if (({1'b0, st.bytes_emitted} + 17'd2) < {1'b0, i_cap}) begin
                if (cnt != 2'd3) begin
                    res[cnt] = '{data: i_byte, done: 1'b0, eof: 1'b0, last: 1'b0};
                end
                cnt = cnt + 2'd1;
                if (st.bytes_emitted != 16'hFFFF) begin
                    st.bytes_emitted = st.bytes_emitted + 16'd1;
                end
                st.word_open = 1'b1;
            end
            st.mode = MODE_NORMAL;
        end

        if (endl) begin
            if (st.word_open) begin
                if (cnt != 2'd3) begin
                    res[cnt] = '{data: 8'h00, done: 1'b0, eof: 1'b0, last: 1'b0};
                end
                cnt = cnt + 2'd1;
            end
            if (cnt != 2'd3) begin
                res[cnt] = '{data: 8'h00, done: 1'b1, eof: endeof, last: 1'b0};
            end
            cnt              = cnt + 2'd1;
            st.mode          = MODE_SKIP;
            st.quote         = QUOTE_NONE;
            st.word_open     = 1'b0;
            st.bytes_emitted = 16'd0;
        end

        if (cnt != 2'd0) begin
            res[cnt - 2'd1].last = 1'b1;
        end
    end

    assign o_state = st;
    assign o_res   = res;
    assign o_cnt   = cnt;

endmodule

@@ src/config_line_tokenizer.sv @@
// Latency: the first result of an item is presented the cycle after its input transfer.
// Throughput: one item per cycle while each item gives at most one result and the output
// is not stalled; an item with k results (k up to 3) holds the input until its last result
// leaves, as the output register bank drains one result per cycle while not stalled.
// Reset: synchronous, active low; clears scan state, empties the result bank and
// sets the line capacity (r_cap) to 1024.
module config_line_tokenizer import clt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_file,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_line_done,
    output logic        o_ended_by_eof,
    output logic        o_last
);

    t_state                r_state;
    t_state                n_state;
    logic [15:0]           r_cap;
    t_result [RES_MAX-1:0] r_buf;
    logic [1:0]            r_cnt;
    t_result [RES_MAX-1:0] step_res;
    logic [1:0]            step_cnt;
    logic                  in_xfer;
    logic                  out_xfer;
    logic                  ready;

    clt_step u_step (
        .i_state (r_state),
        .i_cap   (r_cap),
        .i_byte  (i_in_byte),
        .i_eof   (i_end_of_file),
        .o_state (n_state),
        .o_res   (step_res),
        .o_cnt   (step_cnt)
    );

    // take a new item once the bank is empty or its last entry leaves this cycle
    assign ready    = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && !i_out_stall);
    assign in_xfer  = i_in_valid && ready;
    assign out_xfer = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: MODE_SKIP, quote: QUOTE_NONE, word_open: 1'b0,
                         bytes_emitted: 16'd0};
            r_cap   <= CAP_RESET;
            r_cnt   <= 2'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (in_xfer) begin
                r_state <= n_state;
                r_cnt   <= step_cnt;
            end else if (out_xfer) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_buf <= step_res;
        end else if (out_xfer) begin
            r_buf[0] <= r_buf[1];
            r_buf[1] <= r_buf[2];
        end
    end

    always_comb begin
        o_in_stall     = !ready;
        o_out_valid    = (r_cnt != 2'd0);
        o_out_byte     = r_buf[0].data;
        o_line_done    = r_buf[0].done;
        o_ended_by_eof = r_buf[0].eof;
        o_last         = r_buf[0].last;
    end

    a_bank_full_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > 2'd1) |-> o_in_stall)
        else $error("input taken while results of the previous item remain");

    a_eof_resets_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_end_of_file) |=>
            (r_state.bytes_emitted == 16'd0 && r_state.mode == MODE_SKIP &&
             r_state.quote == QUOTE_NONE && !r_state.word_open))
        else $error("line state not cleared after end of file");

    a_bank_tail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0) |-> r_buf[r_cnt - 2'd1].last)
        else $error("final buffered result lacks its last flag");

    a_line_done_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_line_done) |-> (o_out_byte == 8'h00 && o_last))
        else $error("line end result is not a final zero");

    a_eof_flag_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_ended_by_eof) |-> o_line_done)
        else $error("end of file flag outside a line end");

endmodule
